FILE: rtl/cwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_pkg
// Shared types, codes and the CRC-8 byte update for the word deframer.
// ----------------------------------------------------------------------------
package cwd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam logic [BYTE_W-1:0] CRC_TOP_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] POLY_RESET    = 8'h31;
    localparam logic [BYTE_W-1:0] INIT_RESET    = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT = 2'd1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_FAIL = 2'd1,
        ST_TRUNC    = 2'd2
    } t_status;

    // Position inside the three-byte group
    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_CRC  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              end_of_transfer;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        t_status           status;
        logic              last;
    } t_result;

    // One byte through an MSB-first CRC-8, eight shift steps
    function automatic logic [BYTE_W-1:0] crc8_feed(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((crc & CRC_TOP_BIT) != '0) begin
                crc = {crc[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                crc = {crc[BYTE_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

FILE: rtl/cwd_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_crc8
// CRC-8 over the held data byte pair, high byte first.
// ----------------------------------------------------------------------------
module cwd_crc8 import cwd_pkg::*; (
    input  logic [BYTE_W-1:0] i_poly,
    input  logic [BYTE_W-1:0] i_init,
    input  logic [BYTE_W-1:0] i_high_byte,
    input  logic [BYTE_W-1:0] i_low_byte,
    output logic [BYTE_W-1:0] o_crc
);

    logic [BYTE_W-1:0] crc_mid;

    // Fold in high byte, then low byte
    always_comb begin
        crc_mid = crc8_feed(i_init, i_high_byte, i_poly);
        o_crc   = crc8_feed(crc_mid, i_low_byte, i_poly);
    end

endmodule

FILE: rtl/cwd_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_framer
// Group tracking, CRC check and result register for one item per cycle while the result register is free or draining.
// ----------------------------------------------------------------------------
module cwd_framer import cwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  t_item                i_item,
    output logic                 o_item_take,
    input  logic [BYTE_W-1:0]    i_poly,
    input  logic [BYTE_W-1:0]    i_init,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res
);

    t_phase            r_phase, n_phase;
    logic              r_drop, n_drop;
    logic [BYTE_W-1:0] r_high, n_high;
    logic [BYTE_W-1:0] r_low, n_low;
    logic              r_res_valid;
    t_result           r_res;
    logic              emit;
    t_result           res_next;
    logic [BYTE_W-1:0] crc_calc;

    cwd_crc8 u_crc8 (
        .i_poly      (i_poly),
        .i_init      (i_init),
        .i_high_byte (r_high),
        .i_low_byte  (r_low),
        .o_crc       (crc_calc)
    );

    // Take an item whenever the result register is free or draining
    assign o_item_take = i_item_valid && (!r_res_valid || i_res_ready);

    // Next phase and drop flag
    always_comb begin
        n_phase = r_phase;
        n_drop  = r_drop;
        if (o_item_take) begin
            if (r_drop) begin
                if (i_item.end_of_transfer) begin
                    n_drop  = 1'b0;
                    n_phase = PH_HIGH;
                end
            end else begin
                unique case (r_phase)
                    PH_LOW: begin
                        n_phase = i_item.end_of_transfer ? PH_HIGH : PH_CRC;
                    end
                    PH_CRC: begin
                        n_phase = PH_HIGH;
                        n_drop  = (crc_calc != i_item.rx_byte)
                                  && !i_item.end_of_transfer;
                    end
                    default: begin
                        n_phase = i_item.end_of_transfer ? PH_HIGH : PH_LOW;
                    end
                endcase
            end
        end
    end

    // Byte holds and result
    always_comb begin
        n_high             = r_high;
        n_low              = r_low;
        emit               = 1'b0;
        res_next.data_word = '0;
        res_next.status    = ST_TRUNC;
        res_next.last      = 1'b1;
        if (o_item_take && !r_drop) begin
            unique case (r_phase)
                PH_LOW: begin
                    n_low = i_item.rx_byte;
                    emit  = i_item.end_of_transfer;
                end
                PH_CRC: begin
                    emit = 1'b1;
                    if (crc_calc == i_item.rx_byte) begin
                        res_next.data_word = {r_high, r_low};
                        res_next.status    = ST_OK;
                        res_next.last      = i_item.end_of_transfer;
                    end else begin
                        res_next.status = ST_CRC_FAIL;
                    end
                end
                default: begin
                    n_high = i_item.rx_byte;
                    emit   = i_item.end_of_transfer;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HIGH;
            r_drop      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_drop  <= n_drop;
            if (emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_high <= n_high;
        r_low  <= n_low;
        if (emit) begin
            r_res <= res_next;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: rtl/crc8_word_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_word_deframer
// Deframes received bytes into 16-bit words checked by a CRC-8.
//
// Bytes arrive in groups of three, one item per cycle while not stalled:
// data high, data low, then an MSB-first CRC-8 over the pair. Each finished
// group yields one result (ok with the word, or crc fail); a failure drops
// the rest of the transfer, and a transfer ending mid-group yields a
// truncated result. An input register holds the byte, the CRC and group
// check are combinational, and a result register feeds the output. The user
// writes polynomial and initial value on the configuration port (index 0
// and 1) only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module crc8_word_deframer import cwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_end_of_transfer,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_data_word,
    output logic [1:0]           o_status,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic              r_stg_valid;
    t_item             r_stg_item;
    logic              stg_take;
    logic [BYTE_W-1:0] r_poly;
    logic [BYTE_W-1:0] r_init;
    t_result           res;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
            r_init <= INIT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_POLY) begin
                r_poly <= i_cfg_data;
            end else if (i_cfg_index == CFG_INIT) begin
                r_init <= i_cfg_data;
            end
        end
    end

    // Input register: refill as the framer drains it
    assign o_in_ready = !r_stg_valid || stg_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_stg_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_stg_item.rx_byte         <= i_rx_byte;
            r_stg_item.end_of_transfer <= i_end_of_transfer;
        end
    end

    cwd_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_stg_valid),
        .i_item       (r_stg_item),
        .o_item_take  (stg_take),
        .i_poly       (r_poly),
        .i_init       (r_init),
        .o_res_valid  (o_out_valid),
        .i_res_ready  (i_out_ready),
        .o_res        (res)
    );

    assign o_data_word = res.data_word;
    assign o_status    = res.status;
    assign o_last      = res.last;

endmodule

FILE: rtl/cwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module cwd_checker import cwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic [WORD_W-1:0]    o_data_word,
    input  logic [1:0]           o_status,
    input  logic                 o_last
);

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_word)
        && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // Failures end the transfer and carry no word
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_CRC_FAIL || o_status == ST_TRUNC)
        |-> o_last && o_data_word == '0)
        else $error("failed result without last or with data");

    // Status code stays in range
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_CRC_FAIL
        || o_status == ST_TRUNC)
        else $error("undefined status code");

    // A newly valid result must trace back to an accepted input item
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without an accepted item");

endmodule

bind crc8_word_deframer cwd_checker u_cwd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_data_word (o_data_word),
    .o_status    (o_status),
    .o_last      (o_last)
);
